// ----- src/lfu_cache_pkg.sv -----
// package for the use-count ordered key cache
// holds the shared command/status types and size constants; no dependencies
package lfu_cache_pkg;

  localparam int unsigned CAPACITY_DEF = 256;
  localparam int unsigned KEY_W        = 16;
  localparam int unsigned USES_W       = 32;
  localparam int unsigned SLOT_W       = 9;

  // controller to datapath commands
  typedef struct packed {
    logic start_search;  // load key, reset search pointer
    logic step_search;   // compare one slot, advance pointer on a mismatch
    logic start_evict;   // drop the tail half when over capacity
    logic step_move;     // shift one entry back toward the tail
    logic write_entry;   // write key and count at the destination
  } lfu_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic search_done;   // pointer reached occupancy
    logic found;         // current slot holds the key
    logic move_done;     // destination reached
    logic over_cap;      // occupancy above capacity
  } lfu_sts_t;

endpackage

// ----- src/lfu_sorted_glyph_cache_top.sv -----
// Use-count ordered key cache, one request in flight at a time.
// A hit is found by a linear search and moved toward the head; an insert searches all
// entries, evicts when over capacity, shifts and writes; a miss without load only searches (one slot compared a cycle).
// A new request is accepted only after the result is taken and the controller is back in idle.
// Reset (rst_n low, synchronous) empties the list; slot memories are not cleared.
// Depends on lfu_cache_pkg, lfu_cache_ctrl and lfu_cache_dp.
module lfu_sorted_glyph_cache_top
  import lfu_cache_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // glyph_key[15:0]
  input  logic        in_tuser,   // load_ok
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // hit, inserted, evicted_half, final_slot[8:0],
                                  // entry_uses[31:0], zero pad[3:0]
  output logic        out_tuser   // unused flag, always 0
);

  lfu_cmd_t          cmd;
  lfu_sts_t          sts;
  logic              in_fire, out_fire;
  logic              res_load, res_hit, res_ins, res_ev, res_none, miss_insert, out_busy;
  logic [SLOT_W-1:0] dst_slot;
  logic [USES_W-1:0] new_uses;
  logic [43:0]       res_r;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  lfu_cache_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_load(in_tuser), .out_fire, .sts, .cmd,
    .in_ready(in_tready), .res_load, .res_hit, .res_ins, .res_ev, .res_none,
    .miss_insert, .out_busy
  );

  lfu_cache_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk, .rst_n, .cmd, .miss_insert, .in_key(in_tdata), .sts, .dst_slot, .new_uses
  );

  // result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      if (res_none) res_r <= '0;
      else res_r <= {new_uses, dst_slot, res_ev, res_ins, res_hit};
    end
  end

  assign out_tvalid = out_busy;
  assign out_tdata  = {4'b0, res_r};
  assign out_tuser  = 1'b0;

`ifndef NO_ASSERTIONS
  // no new transaction while a result is pending
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accept while result pending");
  // result flags are exclusive
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1])) else $error("hit and insert");
  // eviction only with an insert
  a_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2]) |-> out_tdata[1]) else $error("evict without insert");
`endif

endmodule

// ----- src/lfu_cache_dp.sv -----
// datapath of the use-count ordered key cache: key and count memories,
// search pointer and shift pointer; depends on lfu_cache_pkg
module lfu_cache_dp
  import lfu_cache_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lfu_cmd_t          cmd,
  input  logic              miss_insert,  // write mode: 1 insert, 0 hit move
  input  logic [KEY_W-1:0]  in_key,
  output lfu_sts_t          sts,
  output logic [SLOT_W-1:0] dst_slot,
  output logic [USES_W-1:0] new_uses
);

  localparam int unsigned DEPTH = CAPACITY + 1;
  localparam int unsigned IW    = $clog2(DEPTH + 1);
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [KEY_W-1:0]  keys_mem [DEPTH];
  logic [USES_W-1:0] uses_mem [DEPTH];

  logic [IW-1:0]     occ_r, occ_nxt;
  logic [IW-1:0]     ptr_r, ptr_nxt;      // search index / move index
  logic [KEY_W-1:0]  key_r;
  logic [USES_W-1:0] u_r, u_nxt;          // count for the entry being placed
  logic [KEY_W-1:0]  rd_key_r, rd_key_prev_r;
  logic [USES_W-1:0] rd_uses_r, rd_uses_prev_r;
  logic [AW-1:0]     ptr_a, rd_a, rd_prev_a;
  logic              move_here;

  assign ptr_a = ptr_r[AW-1:0];

  // read addresses follow the next pointer so registered data lines up with ptr_r
  assign rd_a      = (ptr_nxt > IW'(DEPTH - 1)) ? AW'(DEPTH - 1) : ptr_nxt[AW-1:0];
  assign rd_prev_a = (ptr_nxt == '0) ? '0 : AW'(ptr_nxt - IW'(1));

  assign sts.search_done = (ptr_r >= occ_r);
  assign sts.found       = (ptr_r < occ_r) && (rd_key_r == key_r);
  assign sts.over_cap    = (occ_r > IW'(CAPACITY));
  assign move_here       = (ptr_r == '0) || (rd_uses_prev_r > u_r);
  assign sts.move_done   = move_here;

  assign dst_slot = SLOT_W'(ptr_r);
  assign new_uses = u_r;

  // pointer, occupancy and count update
  always_comb begin
    ptr_nxt = ptr_r;
    occ_nxt = occ_r;
    u_nxt   = u_r;
    if (cmd.start_search) begin
      ptr_nxt = '0;
    end else if (cmd.step_search) begin
      if (sts.found) begin
        u_nxt = (rd_uses_r == '1) ? rd_uses_r : rd_uses_r + USES_W'(1);
      end else begin
        ptr_nxt = ptr_r + IW'(1);
      end
    end else if (cmd.start_evict) begin
      u_nxt = USES_W'(1);
      if (sts.over_cap) begin
        occ_nxt = occ_r - IW'(CAPACITY / 2);
        ptr_nxt = occ_r - IW'(CAPACITY / 2);
      end else begin
        ptr_nxt = occ_r;
      end
    end else if (cmd.step_move && !move_here) begin
      ptr_nxt = ptr_r - IW'(1);
    end else if (cmd.write_entry && miss_insert) begin
      occ_nxt = occ_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      ptr_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      ptr_r <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r <= u_nxt;
    if (cmd.start_search) key_r <= in_key;
  end

  // memory writes: shift one entry back, or place the entry; registered reads
  always_ff @(posedge clk) begin
    if (cmd.step_move && !move_here) begin
      keys_mem[ptr_a] <= rd_key_prev_r;
      uses_mem[ptr_a] <= rd_uses_prev_r;
    end else if (cmd.write_entry) begin
      keys_mem[ptr_a] <= key_r;
      uses_mem[ptr_a] <= u_r;
    end
    rd_key_r       <= keys_mem[rd_a];
    rd_uses_r      <= uses_mem[rd_a];
    rd_key_prev_r  <= keys_mem[rd_prev_a];
    rd_uses_prev_r <= uses_mem[rd_prev_a];
  end

endmodule

// ----- src/lfu_cache_ctrl.sv -----
// controller of the use-count ordered key cache: sequences search,
// eviction, shift and write; owns the handshakes; depends on lfu_cache_pkg
module lfu_cache_ctrl
  import lfu_cache_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     in_load,
  input  logic     out_fire,
  input  lfu_sts_t sts,
  output lfu_cmd_t cmd,
  output logic     in_ready,
  output logic     res_load,     // capture result fields this cycle
  output logic     res_hit,
  output logic     res_ins,
  output logic     res_ev,
  output logic     res_none,
  output logic     miss_insert,
  output logic     out_busy
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_EVICT  = 6'b000100,
    S_MOVE   = 6'b001000,
    S_WRITE  = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   load_r, hit_r, hit_nxt, ev_r, ev_nxt;

  assign in_ready    = (state_r == S_IDLE);
  assign miss_insert = !hit_r;
  assign out_busy    = (state_r == S_OUT);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    hit_nxt   = hit_r;
    ev_nxt    = ev_r;
    cmd       = '0;
    res_load  = 1'b0;
    res_hit   = hit_r;
    res_ins   = !hit_r;
    res_ev    = ev_r;
    res_none  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.start_search = 1'b1;
          hit_nxt   = 1'b0;
          ev_nxt    = 1'b0;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.step_search = 1'b1;
        if (sts.found) begin
          hit_nxt   = 1'b1;
          state_nxt = S_MOVE;
        end else if (sts.search_done) begin
          if (load_r) begin
            state_nxt = S_EVICT;
          end else begin
            res_load  = 1'b1;
            res_none  = 1'b1;
            state_nxt = S_OUT;
          end
        end
      end
      S_EVICT: begin
        cmd.start_evict = 1'b1;
        ev_nxt    = sts.over_cap;
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        cmd.step_move = 1'b1;
        if (sts.move_done) state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.write_entry = 1'b1;
        res_load  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hit_r   <= 1'b0;
      ev_r    <= 1'b0;
      load_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hit_r   <= hit_nxt;
      ev_r    <= ev_nxt;
      if (in_fire) load_r <= in_load;
    end
  end

endmodule
